// ===== rtl/cmg_pkg.sv =====
// ----------------------------------------------------------------------------
// Cylinder mesh generator package
// Shared constants, the CORDIC angle table and the cell handoff type.
// ----------------------------------------------------------------------------
`default_nettype none
package cmg_pkg;

    localparam int MAX_SLICES_DEF   = 256;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;

    // Configuration register indexes.
    localparam logic [2:0] REG_RADIUS = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SLICES = 3'd2;
    localparam logic [2:0] REG_CAPPED = 3'd3;
    localparam logic [2:0] REG_COLOR  = 3'd4;

    localparam logic [31:0] CORDIC_X0 = 32'h26DD3B6A;

    // Arctangent of 2^-k in turns scaled by 2^32.
    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] r;
        begin
            case (k)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    // Data handed from one CORDIC cell to the next.
    typedef struct packed {
        logic        vld;
        logic [9:0]  step;
        logic [1:0]  quad;
        logic [16:0] tex_u;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } cell_t;

endpackage
`default_nettype wire

// ===== rtl/cmg_div.sv =====
// ----------------------------------------------------------------------------
// Cylinder mesh restoring divider
// Pipelined quotient of a left-aligned numerator by the slice count, one
// quotient bit per stage, rounded to nearest by a half-divisor bias.
// ----------------------------------------------------------------------------
`default_nettype none
module cmg_div #(
    parameter int SW = 11
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_vld,
    input  wire logic [9:0]    in_step,
    input  wire logic [SW-1:0] in_div,
    output logic               out_vld,
    output logic [9:0]         out_step,
    output logic [31:0]        out_phase,
    output logic [16:0]        out_u
);
    // Numerator is (step << 32) + div/2; 32 quotient bits are needed.
    localparam int NB = 32;
    localparam int RW = SW + 1;

    logic [NB:0]   vld_reg;
    logic [9:0]    step_reg [NB+1];
    logic [SW-1:0] div_reg  [NB+1];
    logic [RW-1:0] rem_reg  [NB+1];
    logic [31:0]   num_reg  [NB+1];
    logic [31:0]   q_reg    [NB+1];

    // Stage 0 loads the biased numerator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NB-1:0], in_vld};
        end
    end

    // The step itself is the upper part of the numerator and starts out as
    // the remainder. A full turn leaves remainder zero after its quotient
    // bit of weight 2^32, which is dropped modulo 2^32.
    always_ff @(posedge clk)
    begin
        step_reg[0] <= in_step;
        div_reg[0]  <= in_div;
        num_reg[0]  <= 32'(in_div >> 1);
        rem_reg[0]  <= (32'(in_step) >= 32'(in_div)) ? '0 : RW'(in_step);
        q_reg[0]    <= '0;
    end

    // Each stage shifts in one numerator bit and tries one subtract.
    for (genvar g = 0; g < NB; g++)
    begin : g_stage
        logic [RW-1:0] rem_next;
        logic [RW:0]   trial;
        logic [RW-1:0] shifted;
        always_comb
        begin
            shifted = {rem_reg[g][RW-2:0], num_reg[g][31]};
            trial   = {1'b0, shifted} - {2'b0, div_reg[g]};
            rem_next = trial[RW] ? shifted : trial[RW-1:0];
        end
        always_ff @(posedge clk)
        begin
            step_reg[g+1] <= step_reg[g];
            div_reg[g+1]  <= div_reg[g];
            num_reg[g+1]  <= {num_reg[g][30:0], 1'b0};
            rem_reg[g+1]  <= rem_next;
            q_reg[g+1]    <= {q_reg[g][30:0], ~trial[RW]};
        end
    end

    // The full turn wraps the phase to zero, but its texture u is one, so
    // the dropped quotient bit is restored for u.
    logic full_turn;
    assign full_turn = (32'(step_reg[NB]) == 32'(div_reg[NB]));

    assign out_vld   = vld_reg[NB];
    assign out_step  = step_reg[NB];
    assign out_phase = q_reg[NB];
    assign out_u     = 17'({full_turn, q_reg[NB][31:16]}) + 17'(q_reg[NB][15]);
endmodule
`default_nettype wire

// ===== rtl/cmg_cell.sv =====
// ----------------------------------------------------------------------------
// Cylinder mesh CORDIC cell
// One rotation-mode CORDIC iteration with a fixed shift, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module cmg_cell #(
    parameter int K = 0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cmg_pkg::cell_t din,
    output cmg_pkg::cell_t      dout
);
    cmg_pkg::cell_t c_next;
    cmg_pkg::cell_t data_reg;
    logic           vld_reg;
    logic signed [33:0] ang;

    // Rotate toward zero residual angle.
    always_comb
    begin
        ang    = 34'(cmg_pkg::atan_turn(5'(K)));
        c_next = din;
        if (!din.z[33])
        begin
            c_next.x = din.x - (din.y >>> K);
            c_next.y = din.y + (din.x >>> K);
            c_next.z = din.z - ang;
        end
        else
        begin
            c_next.x = din.x + (din.y >>> K);
            c_next.y = din.y - (din.x >>> K);
            c_next.z = din.z + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= din.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= c_next;
    end

    // Only the valid bit is reset.
    always_comb
    begin
        dout     = data_reg;
        dout.vld = vld_reg;
    end
endmodule
`default_nettype wire

// ===== rtl/cylinder_mesh_generator.sv =====
// ----------------------------------------------------------------------------
// Cylinder mesh generator
// An accepted step passes the divider stages, the CORDIC cells, the multiply
// stage and the result queue before its first word reaches the result port.
// Throughput: one word a cycle while out_stall is low; a step gives six words
// capped and four not, the closing step four or two, and a rejected step none.
// Reset clears the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module cylinder_mesh_generator #(
    parameter int MAX_SLICES   = cmg_pkg::MAX_SLICES_DEF,
    parameter int CORDIC_STEPS = cmg_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [8:0]         step,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    result_kind,
    output logic [9:0]              slot,
    output logic signed [16:0]      pos_x,
    output logic signed [16:0]      pos_y,
    output logic signed [16:0]      pos_z,
    output logic signed [15:0]      norm_x,
    output logic signed [15:0]      norm_y,
    output logic signed [15:0]      norm_z,
    output logic [16:0]             tex_u,
    output logic [16:0]             tex_v,
    output logic [31:0]             color,
    output logic                    last
);
    localparam int SW    = $clog2(MAX_SLICES + 1);
    localparam int NC    = (CORDIC_STEPS < cmg_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                              : cmg_pkg::TABLE_LEN;
    localparam int FDEP  = 32;
    localparam int FAW   = $clog2(FDEP);

    // Configuration registers.
    logic [15:0] radius_reg, height_reg;
    logic [8:0]  slices_reg;
    logic        capped_reg;
    logic [31:0] color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd256;
            height_reg <= 16'd512;
            slices_reg <= 9'd16;
            capped_reg <= 1'b1;
            color_reg  <= 32'hFFFFFFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cmg_pkg::REG_RADIUS: radius_reg <= cfg_data[15:0];
                cmg_pkg::REG_HEIGHT: height_reg <= cfg_data[15:0];
                cmg_pkg::REG_SLICES: slices_reg <= cfg_data[8:0];
                cmg_pkg::REG_CAPPED: capped_reg <= cfg_data[0];
                cmg_pkg::REG_COLOR:  color_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective slice count clamped to 3..MAX_SLICES.
    logic [SW-1:0] s_eff;
    always_comb
    begin
        if (slices_reg < 9'd3)
            s_eff = SW'(3);
        else if (32'(slices_reg) > MAX_SLICES)
            s_eff = SW'(MAX_SLICES);
        else
            s_eff = SW'(slices_reg);
    end

    logic [16:0] half_h;
    assign half_h = 17'(({1'b0, height_reg} + 17'd1) >> 1);

    // Credits bound the items in flight so the result queue never overflows.
    logic [FAW:0] credit_reg;
    logic         in_acc, deq;
    logic         step_ok;
    assign in_stall = (credit_reg == '0);
    assign in_acc   = in_valid && !in_stall;
    assign step_ok  = (radius_reg != 16'd0) && (height_reg != 16'd0)
                      && ({1'b0, step} <= 10'(s_eff));

    // Phase and texture u from the divider.
    logic        d_vld;
    logic [9:0]  d_step;
    logic [31:0] d_phase;
    logic [16:0] d_u;

    cmg_div #(.SW(SW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (in_acc && step_ok),
        .in_step  ({1'b0, step}),
        .in_div   (s_eff),
        .out_vld  (d_vld),
        .out_step (d_step),
        .out_phase(d_phase),
        .out_u    (d_u)
    );

    // Chain of CORDIC cells.
    cmg_pkg::cell_t chain [NC+1];
    cmg_pkg::cell_t chain_in;
    always_comb
    begin
        chain_in.vld   = d_vld;
        chain_in.step  = d_step;
        chain_in.quad  = d_phase[31:30];
        chain_in.tex_u = d_u;
        chain_in.x     = 34'(signed'({2'b0, cmg_pkg::CORDIC_X0}));
        chain_in.y     = '0;
        chain_in.z     = 34'({4'b0, d_phase[29:0]});
    end
    assign chain[0] = chain_in;

    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        cmg_cell #(.K(k)) u_cell (
            .clk (clk),
            .rst_n(rst_n),
            .din (chain[k]),
            .dout(chain[k+1])
        );
    end

    // Clamp and quadrant map.
    function automatic logic signed [33:0] clamp30(input logic signed [33:0] v);
        begin
            if (v > 34'sh40000000)
                return 34'sh40000000;
            else if (v < -34'sh40000000)
                return -34'sh40000000;
            else
                return v;
        end
    endfunction

    // Divide by 2^k rounding half away from zero.
    function automatic logic signed [49:0] rnd(input logic signed [49:0] v,
                                               input int k);
        logic [49:0] mag;
        logic [49:0] q;
        begin
            mag = v[49] ? 50'(-v) : 50'(v);
            q   = (mag + (50'd1 << (k - 1))) >> k;
            return v[49] ? -$signed(q) : $signed(q);
        end
    endfunction

    logic signed [33:0] cx, cy, cos_v, sin_v;
    assign cx = clamp30(chain[NC].x);
    assign cy = clamp30(chain[NC].y);
    always_comb
    begin
        case (chain[NC].quad)
            2'd0:    begin cos_v = cx;  sin_v = cy;  end
            2'd1:    begin cos_v = -cy; sin_v = cx;  end
            2'd2:    begin cos_v = -cx; sin_v = -cy; end
            default: begin cos_v = cy;  sin_v = -cx; end
        endcase
    end

    // Multiply stage.
    logic               m_vld_reg;
    logic [9:0]         m_step_reg;
    logic [16:0]        m_u_reg;
    logic signed [49:0] m_px_reg, m_pz_reg;
    logic signed [33:0] m_c_reg, m_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else
            m_vld_reg <= chain[NC].vld;
    end

    always_ff @(posedge clk)
    begin
        m_step_reg <= chain[NC].step;
        m_u_reg    <= chain[NC].tex_u;
        m_c_reg    <= cos_v;
        m_s_reg    <= sin_v;
        m_px_reg   <= 50'(cos_v) * 50'(signed'({1'b0, radius_reg}));
        m_pz_reg   <= 50'(sin_v) * 50'(signed'({1'b0, radius_reg}));
    end

    // Round and saturate into a queue entry.
    logic signed [49:0] nxw, nzw, pxw, pzw;
    logic signed [15:0] nx_q, nz_q;
    assign nxw = rnd(50'(m_c_reg), 15);
    assign nzw = rnd(50'(m_s_reg), 15);
    assign pxw = rnd(m_px_reg, 30);
    assign pzw = rnd(m_pz_reg, 30);
    assign nx_q = (nxw > 50'sd32767) ? 16'sd32767 : 16'(nxw);
    assign nz_q = (nzw > 50'sd32767) ? 16'sd32767 : 16'(nzw);

    typedef struct packed {
        logic [9:0]  step;
        logic [16:0] px;
        logic [16:0] pz;
        logic [15:0] nx;
        logic [15:0] nz;
        logic [16:0] u;
    } qent_t;

    qent_t mem [FDEP];
    logic [FAW-1:0] wp_reg, rp_reg;
    logic [FAW:0]   cnt_reg;
    qent_t          head;

    always_ff @(posedge clk)
    begin
        if (m_vld_reg)
            mem[wp_reg] <= '{m_step_reg, 17'(pxw), 17'(pzw), nx_q, nz_q, m_u_reg};
    end
    assign head = mem[rp_reg];

    // Result sequencer walks up to six words per queued step.
    logic [2:0] idx_reg;
    logic [2:0] nres;
    logic       have;
    logic       fire;
    logic       is_end;
    assign have   = (cnt_reg != '0);
    assign is_end = (head.step == 10'(s_eff));
    assign nres   = is_end ? (capped_reg ? 3'd4 : 3'd2)
                           : (capped_reg ? 3'd6 : 3'd4);
    assign fire   = have && (!out_valid || !out_stall);
    assign deq    = fire && (idx_reg == nres - 3'd1);

    // Word formation.
    logic [9:0] s10, i10, t0, cb;
    always_comb
    begin
        s10 = 10'(s_eff);
        i10 = head.step;
        t0  = s10 + 10'd1 + i10;
        cb  = (s10 << 1) + 10'd2;
    end

    logic        w_kind;
    logic [9:0]  w_slot;
    logic [16:0] w_a, w_b, w_c, w_u, w_v;
    logic [15:0] w_nx, w_ny, w_nz;
    logic [31:0] w_col;
    always_comb
    begin
        w_kind = 1'b1; w_slot = '0; w_a = '0; w_b = '0; w_c = '0;
        w_nx = '0; w_ny = '0; w_nz = '0; w_u = '0; w_v = '0; w_col = '0;
        case (idx_reg)
            3'd0, 3'd1:
            begin
                w_kind = 1'b0;
                w_slot = (idx_reg == 3'd0) ? i10 : t0;
                w_a = head.px; w_c = head.pz;
                w_b = (idx_reg == 3'd0) ? -half_h : half_h;
                w_nx = head.nx; w_nz = head.nz; w_u = head.u;
                w_v = (idx_reg == 3'd0) ? 17'd0 : 17'd65536;
                w_col = color_reg;
            end
            default:
            begin
                if (is_end)
                begin
                    w_kind = 1'b0;
                    w_slot = (idx_reg == 3'd2) ? cb : cb + 10'd1;
                    w_b  = (idx_reg == 3'd2) ? -half_h : half_h;
                    w_ny = (idx_reg == 3'd2) ? 16'h8000 : 16'h7FFF;
                    w_u = 17'd32768; w_v = 17'd32768; w_col = color_reg;
                end
                else
                begin
                    case (idx_reg)
                        3'd2: begin w_slot = i10 << 1;
                            w_a = 17'(i10); w_b = 17'(t0); w_c = 17'(i10 + 10'd1); end
                        3'd3: begin w_slot = (i10 << 1) + 10'd1;
                            w_a = 17'(i10 + 10'd1); w_b = 17'(t0); w_c = 17'(t0 + 10'd1); end
                        3'd4: begin w_slot = (s10 << 1) + i10;
                            w_a = 17'(cb); w_b = 17'(i10 + 10'd1); w_c = 17'(i10); end
                        default: begin w_slot = (s10 << 1) + s10 + i10;
                            w_a = 17'(cb + 10'd1); w_b = 17'(t0); w_c = 17'(t0 + 10'd1); end
                    endcase
                end
            end
        endcase
    end

    // Queue, credit and output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            rp_reg     <= '0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            credit_reg <= (FAW+1)'(FDEP);
            out_valid  <= 1'b0;
        end
        else
        begin
            if (m_vld_reg)
                wp_reg <= wp_reg + 1'b1;
            if (deq)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (FAW+1)'(m_vld_reg) - (FAW+1)'(deq);
            credit_reg <= credit_reg - (FAW+1)'(in_acc && step_ok) + (FAW+1)'(deq);
            if (fire)
                idx_reg <= deq ? 3'd0 : idx_reg + 3'd1;
            if (fire)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_kind <= w_kind;
            slot        <= w_slot;
            pos_x       <= w_a;
            pos_y       <= w_b;
            pos_z       <= w_c;
            norm_x      <= w_nx;
            norm_y      <= w_ny;
            norm_z      <= w_nz;
            tex_u       <= w_u;
            tex_v       <= w_v;
            color       <= w_col;
            last        <= deq;
        end
    end
endmodule
`default_nettype wire
